// ===== src/h2fh_pkg.sv =====
`default_nettype none
package h2fh_pkg;

  localparam int HEADER_BYTES = 9;
  localparam int HDR_CNT_W    = 4;
  localparam int SHIFT_W      = 8 * (HEADER_BYTES - 1);

  localparam logic [HDR_CNT_W-1:0] HDR_LAST = HDR_CNT_W'(HEADER_BYTES - 1);

  localparam logic [23:0] MAX_FRAME_RESET = 24'hFFFFFF;

  localparam logic [7:0] FT_DATA          = 8'd0;
  localparam logic [7:0] FT_HEADERS       = 8'd1;
  localparam logic [7:0] FT_PRIORITY      = 8'd2;
  localparam logic [7:0] FT_RST_STREAM    = 8'd3;
  localparam logic [7:0] FT_SETTINGS      = 8'd4;
  localparam logic [7:0] FT_PUSH_PROMISE  = 8'd5;
  localparam logic [7:0] FT_PING          = 8'd6;
  localparam logic [7:0] FT_GOAWAY        = 8'd7;
  localparam logic [7:0] FT_WINDOW_UPDATE = 8'd8;
  localparam logic [7:0] FT_CONTINUATION  = 8'd9;

  localparam logic [2:0] ST_OK           = 3'd0;
  localparam logic [2:0] ST_TOO_LARGE    = 3'd1;
  localparam logic [2:0] ST_NEED_NONZERO = 3'd2;
  localparam logic [2:0] ST_NEED_ZERO    = 3'd3;
  localparam logic [2:0] ST_BAD_SIZE     = 3'd4;

  localparam logic [23:0] LEN_PRIORITY = 24'd5;
  localparam logic [23:0] LEN_FOUR     = 24'd4;
  localparam logic [23:0] LEN_EIGHT    = 24'd8;

  typedef struct packed {
    logic [23:0] frame_length;
    logic [7:0]  frame_type;
    logic [7:0]  frame_flags;
    logic [30:0] stream_ident;
  } hdr_t;

  // sum of the four base-4 digits of a byte
  function automatic logic [3:0] byte_dsum(input logic [7:0] v);
    return 4'(v[1:0]) + 4'(v[3:2]) + 4'(v[5:4]) + 4'(v[7:6]);
  endfunction

  // 4 = 1 mod 3, so a value mod 3 follows from its base-4 digit sum
  function automatic logic mod3_is_zero(input logic [23:0] v);
    logic [5:0] s;
    logic [3:0] a;
    logic [2:0] b;
    s = 6'(byte_dsum(v[7:0])) + 6'(byte_dsum(v[15:8])) + 6'(byte_dsum(v[23:16]));
    a = 4'(s[5:4]) + 4'(s[3:2]) + 4'(s[1:0]);
    b = 3'(a[3:2]) + 3'(a[1:0]);
    return (b == 3'd0) || (b == 3'd3);
  endfunction

endpackage
`default_nettype wire

// ===== src/h2fh_in_if.sv =====
`default_nettype none
interface h2fh_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;

  modport source (output valid, output in_byte, input ready);
  modport sink   (input valid, input in_byte, output ready);
endinterface
`default_nettype wire

// ===== src/h2fh_out_if.sv =====
`default_nettype none
interface h2fh_out_if;
  logic        valid;
  logic        ready;
  logic [23:0] frame_length;
  logic [7:0]  frame_type;
  logic [7:0]  frame_flags;
  logic [30:0] stream_ident;
  logic [2:0]  check_status;

  modport source (output valid, output frame_length, output frame_type, output frame_flags,
                  output stream_ident, output check_status, input ready);
  modport sink   (input valid, input frame_length, input frame_type, input frame_flags,
                  input stream_ident, input check_status, output ready);
endinterface
`default_nettype wire

// ===== src/h2fh_deframer.sv =====
`default_nettype none
module h2fh_deframer (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          byte_acc,
  input  wire logic [7:0]    byte_in,
  output h2fh_pkg::hdr_t     hdr,
  output logic               hdr_done
);

  logic [h2fh_pkg::HDR_CNT_W-1:0] cnt_r, cnt_nxt;
  logic [h2fh_pkg::SHIFT_W-1:0]   shift_r, shift_nxt;
  logic [23:0]                    pay_r, pay_nxt;

  assign hdr.frame_length = shift_r[h2fh_pkg::SHIFT_W-1 -: 24];
  assign hdr.frame_type   = shift_r[h2fh_pkg::SHIFT_W-25 -: 8];
  assign hdr.frame_flags  = shift_r[h2fh_pkg::SHIFT_W-33 -: 8];
  assign hdr.stream_ident = {shift_r[22:0], byte_in};

  assign hdr_done = byte_acc && (pay_r == '0) && (cnt_r == h2fh_pkg::HDR_LAST);

  always_comb begin
    cnt_nxt   = cnt_r;
    shift_nxt = shift_r;
    pay_nxt   = pay_r;
    if (byte_acc) begin
      if (pay_r != '0) begin
        pay_nxt = pay_r - 24'd1;
      end else if (cnt_r != h2fh_pkg::HDR_LAST) begin
        shift_nxt = {shift_r[h2fh_pkg::SHIFT_W-9:0], byte_in};
        cnt_nxt   = cnt_r + h2fh_pkg::HDR_CNT_W'(1);
      end else begin
        cnt_nxt = '0;
        pay_nxt = hdr.frame_length;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r   <= '0;
      shift_r <= '0;
      pay_r   <= '0;
    end else begin
      cnt_r   <= cnt_nxt;
      shift_r <= shift_nxt;
      pay_r   <= pay_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== src/h2fh_rules.sv =====
`default_nettype none
module h2fh_rules (
  input  wire h2fh_pkg::hdr_t hdr,
  input  wire logic [23:0]    max_frame_size,
  output logic [2:0]          status
);

  logic sid_zero;
  logic [23:0] len;

  assign len      = hdr.frame_length;
  assign sid_zero = (hdr.stream_ident == '0);

  always_comb begin
    status = h2fh_pkg::ST_OK;
    if (len > max_frame_size) begin
      status = h2fh_pkg::ST_TOO_LARGE;
    end else begin
      case (hdr.frame_type) inside
        h2fh_pkg::FT_DATA, h2fh_pkg::FT_HEADERS, h2fh_pkg::FT_PUSH_PROMISE,
        h2fh_pkg::FT_CONTINUATION: begin
          if (sid_zero) status = h2fh_pkg::ST_NEED_NONZERO;
        end
        h2fh_pkg::FT_PRIORITY: begin
          if (sid_zero) status = h2fh_pkg::ST_NEED_NONZERO;
          else if (len != h2fh_pkg::LEN_PRIORITY) status = h2fh_pkg::ST_BAD_SIZE;
        end
        h2fh_pkg::FT_RST_STREAM: begin
          if (sid_zero) status = h2fh_pkg::ST_NEED_NONZERO;
          else if (len != h2fh_pkg::LEN_FOUR) status = h2fh_pkg::ST_BAD_SIZE;
        end
        h2fh_pkg::FT_SETTINGS: begin
          if (!sid_zero) status = h2fh_pkg::ST_NEED_ZERO;
          else if (hdr.frame_flags[0]) begin
            if (len != '0) status = h2fh_pkg::ST_BAD_SIZE;
          end else if (len[0] || !h2fh_pkg::mod3_is_zero(len)) begin
            status = h2fh_pkg::ST_BAD_SIZE;
          end
        end
        h2fh_pkg::FT_PING: begin
          if (!sid_zero) status = h2fh_pkg::ST_NEED_ZERO;
          else if (len != h2fh_pkg::LEN_EIGHT) status = h2fh_pkg::ST_BAD_SIZE;
        end
        h2fh_pkg::FT_GOAWAY: begin
          if (!sid_zero) status = h2fh_pkg::ST_NEED_ZERO;
          else if (len < h2fh_pkg::LEN_EIGHT) status = h2fh_pkg::ST_BAD_SIZE;
        end
        h2fh_pkg::FT_WINDOW_UPDATE: begin
          if (len != h2fh_pkg::LEN_FOUR) status = h2fh_pkg::ST_BAD_SIZE;
        end
        default: status = h2fh_pkg::ST_OK;
      endcase
    end
  end

endmodule
`default_nettype wire

// ===== src/http2_frame_header_checker.sv =====
// HTTP/2 frame header checker. Takes the frame stream one byte per item and
// accepts a byte in every clock cycle while the result register is empty or
// being drained in the same cycle; only a held result on the output stalls the
// input. The ninth header byte yields one result item in the next cycle with
// the length, type, flags, stream id (reserved bit cleared) and a check status
// (0 ok, 1 too large, 2 needs nonzero stream, 3 needs stream zero, 4 bad
// payload size). The following frame_length bytes are skipped without a result.
// max_frame_size resets to 0xFFFFFF and should be written only while idle.
`default_nettype none
module http2_frame_header_checker (
  input  wire logic        clk,
  input  wire logic        rst_n,
  h2fh_in_if.sink          in_chan,
  h2fh_out_if.source       out_chan,
  input  wire logic        cfg_we,
  input  wire logic [23:0] cfg_wdata
);

  logic [23:0]     max_r;
  logic            out_valid_r;
  h2fh_pkg::hdr_t  out_hdr_r;
  logic [2:0]      out_status_r;

  logic            byte_acc;
  logic            hdr_done;
  h2fh_pkg::hdr_t  hdr;
  logic [2:0]      status;

  assign in_chan.ready = !out_valid_r || out_chan.ready;
  assign byte_acc      = in_chan.valid && in_chan.ready;

  h2fh_deframer u_deframer (
    .clk      (clk),
    .rst_n    (rst_n),
    .byte_acc (byte_acc),
    .byte_in  (in_chan.in_byte),
    .hdr      (hdr),
    .hdr_done (hdr_done)
  );

  h2fh_rules u_rules (
    .hdr            (hdr),
    .max_frame_size (max_r),
    .status         (status)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_r       <= h2fh_pkg::MAX_FRAME_RESET;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) max_r <= cfg_wdata;
      if (hdr_done) begin
        out_valid_r <= 1'b1;
      end else if (out_chan.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (hdr_done) begin
      out_hdr_r    <= hdr;
      out_status_r <= status;
    end
  end

  assign out_chan.valid        = out_valid_r;
  assign out_chan.frame_length = out_hdr_r.frame_length;
  assign out_chan.frame_type   = out_hdr_r.frame_type;
  assign out_chan.frame_flags  = out_hdr_r.frame_flags;
  assign out_chan.stream_ident = out_hdr_r.stream_ident;
  assign out_chan.check_status = out_status_r;

endmodule
`default_nettype wire

// ===== src/h2fh_sva.sv =====
`default_nettype none
module h2fh_sva (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_ready,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [23:0] frame_length,
  input wire logic [7:0]  frame_type,
  input wire logic [30:0] stream_ident,
  input wire logic [2:0]  check_status
);

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(frame_length) && $stable(check_status))
    else $error("result changed while stalled");

  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid && !out_ready)
    else $error("input stalled without a held result");

  a_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> check_status <= h2fh_pkg::ST_BAD_SIZE)
    else $error("status code out of range");

  a_large: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && check_status == h2fh_pkg::ST_TOO_LARGE |-> frame_length != '0)
    else $error("empty frame flagged too large");

  a_ping: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && frame_type == h2fh_pkg::FT_PING && check_status == h2fh_pkg::ST_OK
      |-> frame_length == h2fh_pkg::LEN_EIGHT && stream_ident == '0)
    else $error("malformed PING passed");

endmodule

bind http2_frame_header_checker h2fh_sva u_h2fh_sva (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_ready     (in_chan.ready),
  .out_valid    (out_chan.valid),
  .out_ready    (out_chan.ready),
  .frame_length (out_chan.frame_length),
  .frame_type   (out_chan.frame_type),
  .stream_ident (out_chan.stream_ident),
  .check_status (out_chan.check_status)
);
`default_nettype wire
